// File: rtl/core/qte_pkg.sv
`default_nettype none

package qte_pkg;

    localparam int QTE_TIME_FRAC_BITS = 16;
    localparam int QTE_TIME_W         = 32;
    localparam int QTE_VAL_W          = 64;

    typedef enum logic [2:0] {
        CFG_START_TIME  = 3'd0,
        CFG_END_TIME    = 3'd1,
        CFG_COEF_FIFTH  = 3'd2,
        CFG_COEF_FOURTH = 3'd3,
        CFG_COEF_THIRD  = 3'd4,
        CFG_COEF_SECOND = 3'd5,
        CFG_COEF_FIRST  = 3'd6,
        CFG_COEF_ZERO   = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REGION_BEFORE = 2'd0,
        REGION_INSIDE = 2'd1,
        REGION_AFTER  = 2'd2
    } t_region;

    // stored registers plus the derivative coefficients formed at write time
    typedef struct packed {
        logic signed [QTE_TIME_W-1:0] start_time;
        logic signed [QTE_TIME_W-1:0] end_time;
        logic signed [QTE_VAL_W-1:0]  c5;
        logic signed [QTE_VAL_W-1:0]  c4;
        logic signed [QTE_VAL_W-1:0]  c3;
        logic signed [QTE_VAL_W-1:0]  c2;
        logic signed [QTE_VAL_W-1:0]  c1;
        logic signed [QTE_VAL_W-1:0]  c0;
        logic signed [QTE_VAL_W-1:0]  c5x5;
        logic signed [QTE_VAL_W-1:0]  c4x4;
        logic signed [QTE_VAL_W-1:0]  c3x3;
        logic signed [QTE_VAL_W-1:0]  c2x2;
        logic signed [QTE_VAL_W-1:0]  c5x20;
        logic signed [QTE_VAL_W-1:0]  c4x12;
        logic signed [QTE_VAL_W-1:0]  c3x6;
        logic                         ovf;
    } t_cfg;

    typedef struct packed {
        logic signed [QTE_VAL_W-1:0] position;
        logic signed [QTE_VAL_W-1:0] velocity;
        logic signed [QTE_VAL_W-1:0] acceleration;
        t_region                     region;
        logic                        overflow;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/qte_cfg.sv
`default_nettype none

module qte_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  qte_pkg::t_cfg_idx             i_index,
    input  logic [qte_pkg::QTE_VAL_W-1:0] i_data,
    output qte_pkg::t_cfg                 o_cfg
);
    import qte_pkg::*;

    localparam logic [4:0] K_TWO  = 5'd2;
    localparam logic [4:0] K_VEL3 = 5'd3;
    localparam logic [4:0] K_VEL4 = 5'd4;
    localparam logic [4:0] K_VEL5 = 5'd5;
    localparam logic [4:0] K_ACC3 = 5'd6;
    localparam logic [4:0] K_ACC4 = 5'd12;
    localparam logic [4:0] K_ACC5 = 5'd20;

    // returns {overflow, saturated c*k}
    function automatic logic [QTE_VAL_W:0] scale_sat(input logic signed [QTE_VAL_W-1:0] c,
                                                     input logic [4:0] k);
        logic signed [QTE_VAL_W+5:0] prod;
        logic                        ovf;
        logic [QTE_VAL_W-1:0]        val;
        prod = (QTE_VAL_W+6)'(c) * $signed({{(QTE_VAL_W+1){1'b0}}, k});
        ovf  = (prod[QTE_VAL_W+5:QTE_VAL_W-1] != {7{prod[QTE_VAL_W+5]}});
        if (ovf) begin
            val = prod[QTE_VAL_W+5] ? {1'b1, {(QTE_VAL_W-1){1'b0}}}
                                    : {1'b0, {(QTE_VAL_W-1){1'b1}}};
        end else begin
            val = prod[QTE_VAL_W-1:0];
        end
        return {ovf, val};
    endfunction

    t_cfg              r_cfg, n_cfg;
    logic [3:0]        r_flag, n_flag;
    logic [QTE_VAL_W:0] w_s2, w_s3, w_s4, w_s5, w_s6, w_s12, w_s20;

    always_comb begin
        w_s2  = scale_sat($signed(i_data), K_TWO);
        w_s3  = scale_sat($signed(i_data), K_VEL3);
        w_s4  = scale_sat($signed(i_data), K_VEL4);
        w_s5  = scale_sat($signed(i_data), K_VEL5);
        w_s6  = scale_sat($signed(i_data), K_ACC3);
        w_s12 = scale_sat($signed(i_data), K_ACC4);
        w_s20 = scale_sat($signed(i_data), K_ACC5);
        n_cfg  = r_cfg;
        n_flag = r_flag;
        if (i_valid) begin
            unique case (i_index)
                CFG_START_TIME:  n_cfg.start_time = i_data[QTE_TIME_W-1:0];
                CFG_END_TIME:    n_cfg.end_time   = i_data[QTE_TIME_W-1:0];
                CFG_COEF_FIFTH: begin
                    n_cfg.c5    = i_data;
                    n_cfg.c5x5  = w_s5[QTE_VAL_W-1:0];
                    n_cfg.c5x20 = w_s20[QTE_VAL_W-1:0];
                    n_flag[0]   = w_s5[QTE_VAL_W] | w_s20[QTE_VAL_W];
                end
                CFG_COEF_FOURTH: begin
                    n_cfg.c4    = i_data;
                    n_cfg.c4x4  = w_s4[QTE_VAL_W-1:0];
                    n_cfg.c4x12 = w_s12[QTE_VAL_W-1:0];
                    n_flag[1]   = w_s4[QTE_VAL_W] | w_s12[QTE_VAL_W];
                end
                CFG_COEF_THIRD: begin
                    n_cfg.c3    = i_data;
                    n_cfg.c3x3  = w_s3[QTE_VAL_W-1:0];
                    n_cfg.c3x6  = w_s6[QTE_VAL_W-1:0];
                    n_flag[2]   = w_s3[QTE_VAL_W] | w_s6[QTE_VAL_W];
                end
                CFG_COEF_SECOND: begin
                    n_cfg.c2    = i_data;
                    n_cfg.c2x2  = w_s2[QTE_VAL_W-1:0];
                    n_flag[3]   = w_s2[QTE_VAL_W];
                end
                CFG_COEF_FIRST:  n_cfg.c1 = i_data;
                CFG_COEF_ZERO:   n_cfg.c0 = i_data;
            endcase
        end
        n_cfg.ovf = |n_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= '0;
            r_flag <= '0;
        end else begin
            r_cfg  <= n_cfg;
            r_flag <= n_flag;
        end
    end

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

endmodule

`default_nettype wire

// File: rtl/core/qte_step.sv
`default_nettype none

module qte_step #(
    parameter int TIME_FRAC_BITS = qte_pkg::QTE_TIME_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [qte_pkg::QTE_VAL_W-1:0] i_acc,
    input  logic [qte_pkg::QTE_TIME_W-1:0]       i_u,
    input  logic signed [qte_pkg::QTE_VAL_W-1:0] i_next,
    input  logic                                 i_ovf,
    output logic signed [qte_pkg::QTE_VAL_W-1:0] o_acc,
    output logic                                 o_ovf
);
    import qte_pkg::*;

    localparam int PROD_W = QTE_VAL_W + QTE_TIME_W;
    localparam int HALF_W = QTE_VAL_W / 2;
    localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (TIME_FRAC_BITS - 1);
    localparam logic [QTE_VAL_W-1:0] VAL_MIN = {1'b1, {(QTE_VAL_W-1){1'b0}}};
    localparam logic [QTE_VAL_W-1:0] VAL_MAX = {1'b0, {(QTE_VAL_W-1){1'b1}}};

    // stage 0: sign and magnitude
    logic                  r0_neg, r0_ovf;
    logic [QTE_VAL_W-1:0]  r0_mag;
    logic [QTE_TIME_W-1:0] r0_u;
    // stage 1: partial products
    logic                  r1_neg, r1_ovf;
    logic [QTE_VAL_W-1:0]  r1_lo, r1_hi;
    // stage 2: full product plus rounding half
    logic                  r2_neg, r2_ovf;
    logic [PROD_W-1:0]     r2_prod;
    // stage 3: saturated sum
    logic [QTE_VAL_W-1:0]  r3_acc;
    logic                  r3_ovf;

    logic [PROD_W-1:0]     w_shift;
    logic [QTE_VAL_W-1:0]  w_lo, w_lim;
    logic                  w_movf, w_cin, w_aovf;
    logic [QTE_VAL_W:0]    w_op;
    logic [QTE_VAL_W+1:0]  w_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_neg  <= i_acc[QTE_VAL_W-1];
            r0_mag  <= i_acc[QTE_VAL_W-1] ? (~i_acc + QTE_VAL_W'(1)) : i_acc;
            r0_u    <= i_u;
            r0_ovf  <= i_ovf;

            r1_neg  <= r0_neg;
            r1_ovf  <= r0_ovf;
            r1_lo   <= {{HALF_W{1'b0}}, r0_mag[HALF_W-1:0]} * {{HALF_W{1'b0}}, r0_u};
            r1_hi   <= {{HALF_W{1'b0}}, r0_mag[QTE_VAL_W-1:HALF_W]} * {{HALF_W{1'b0}}, r0_u};

            r2_neg  <= r1_neg;
            r2_ovf  <= r1_ovf;
            r2_prod <= {r1_hi, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, r1_lo} + RND_HALF;

            r3_acc  <= w_aovf ? (w_sum[QTE_VAL_W+1] ? VAL_MIN : VAL_MAX)
                              : w_sum[QTE_VAL_W-1:0];
            r3_ovf  <= r2_ovf | w_movf | w_aovf;
        end
    end

    always_comb begin
        w_shift = r2_prod >> TIME_FRAC_BITS;
        w_lo    = w_shift[QTE_VAL_W-1:0];
        w_lim   = r2_neg ? VAL_MIN : VAL_MAX;
        w_movf  = (|w_shift[PROD_W-1:QTE_VAL_W]) | (w_lo > w_lim);
        if (w_movf) begin
            w_op = r2_neg ? {1'b1, VAL_MIN} : {1'b0, VAL_MAX};
        end else begin
            w_op = r2_neg ? ~{1'b0, w_lo} : {1'b0, w_lo};
        end
        w_cin  = !w_movf & r2_neg;
        w_sum  = {{2{i_next[QTE_VAL_W-1]}}, i_next} + {w_op[QTE_VAL_W], w_op}
               + {{(QTE_VAL_W+1){1'b0}}, w_cin};
        w_aovf = (w_sum[QTE_VAL_W+1:QTE_VAL_W-1] != {3{w_sum[QTE_VAL_W+1]}});
    end

    assign o_acc = r3_acc;
    assign o_ovf = r3_ovf;

endmodule

`default_nettype wire

// File: rtl/core/qte_outq.sv
`default_nettype none

module qte_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  qte_pkg::t_result i_data,
    output logic             o_en,
    output logic             o_valid,
    input  logic             i_ready,
    output qte_pkg::t_result o_data
);
    import qte_pkg::*;

    logic    r_out_v, r_skid_v;
    t_result r_out, r_skid;
    logic    w_take, w_free;

    assign o_en   = !r_skid_v;
    assign w_take = i_valid & !r_skid_v;
    assign w_free = !r_out_v | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_free) begin
            r_out_v  <= r_skid_v | w_take;
            r_skid_v <= 1'b0;
        end else if (w_take) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_out <= r_skid_v ? r_skid : i_data;
        end
        if (!w_free && w_take) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// File: rtl/core/quintic_trajectory_evaluator.sv
// channel    dir  handshake                     payload
// s_axis     in   s_axis_tvalid/s_axis_tready   tdata: sample_time
// m_axis     out  m_axis_tvalid/m_axis_tready   tdata: position, velocity, acceleration
//                                               tuser: region, overflow
// cfg        in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// One item per cycle, unless the pipeline halts on a full skid entry.
// The clamp register loads at the accepting edge; then come five Horner columns
// of four stages each (abs, two 32x32 multipliers, 96-bit round add, saturating
// add) and the output register.
// Synchronous active-low reset clears the valid bits and the configuration
// registers to zero; pipeline data registers are not reset.
// A stalled output parks one item in a skid entry; the pipeline halts only
// once that entry is full.
`default_nettype none

module quintic_trajectory_evaluator #(
    parameter int TIME_FRAC_BITS = qte_pkg::QTE_TIME_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [qte_pkg::QTE_TIME_W-1:0]   s_axis_tdata,   // [31:0] sample_time
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [3*qte_pkg::QTE_VAL_W-1:0]  m_axis_tdata,   // [63:0] position,
                                                             // [127:64] velocity,
                                                             // [191:128] acceleration
    output logic [2:0]                       m_axis_tuser,   // [1:0] region, [2] overflow
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [2:0]                       i_cfg_index,
    input  logic [qte_pkg::QTE_VAL_W-1:0]    i_cfg_data
);
    import qte_pkg::*;

    localparam int N_COL      = 5;
    localparam int COL_STAGES = 4;
    localparam int LAST       = N_COL * COL_STAGES;
    localparam int U_LAST     = (N_COL - 1) * COL_STAGES;

    t_cfg    w_cfg;
    t_result w_res, w_out;
    logic    w_en;

    logic [LAST:0]         r_v;
    logic [QTE_TIME_W-1:0] r_u [0:U_LAST];
    t_region               r_reg [0:LAST];

    logic signed [QTE_TIME_W-1:0] w_t;
    logic [QTE_TIME_W:0]          w_du, w_de;
    logic [QTE_TIME_W-1:0]        n_u;
    t_region                      n_region;

    logic signed [QTE_VAL_W-1:0] w_p_in [0:N_COL-1];
    logic signed [QTE_VAL_W-1:0] w_p_out [0:N_COL-1];
    logic signed [QTE_VAL_W-1:0] w_p_next [0:N_COL-1];
    logic                        w_p_ovfin [0:N_COL-1];
    logic                        w_p_ovf [0:N_COL-1];
    logic                        w_col_ovf [0:N_COL-1];
    logic signed [QTE_VAL_W-1:0] w_v_in [1:N_COL-1];
    logic signed [QTE_VAL_W-1:0] w_v_out [1:N_COL-1];
    logic signed [QTE_VAL_W-1:0] w_v_next [1:N_COL-1];
    logic                        w_v_ovf [1:N_COL-1];
    logic signed [QTE_VAL_W-1:0] w_a_in [2:N_COL-1];
    logic signed [QTE_VAL_W-1:0] w_a_out [2:N_COL-1];
    logic signed [QTE_VAL_W-1:0] w_a_next [2:N_COL-1];
    logic                        w_a_ovf [2:N_COL-1];

    qte_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .o_ready (o_cfg_ready),
        .i_index (t_cfg_idx'(i_cfg_index)),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // clamp to the segment
    always_comb begin
        w_t  = s_axis_tdata;
        w_du = {w_t[QTE_TIME_W-1], w_t} - {w_cfg.start_time[QTE_TIME_W-1], w_cfg.start_time};
        w_de = {w_cfg.end_time[QTE_TIME_W-1], w_cfg.end_time}
             - {w_cfg.start_time[QTE_TIME_W-1], w_cfg.start_time};
        priority if (w_t < w_cfg.start_time) begin
            n_region = REGION_BEFORE;
            n_u      = '0;
        end else if (w_t > w_cfg.end_time) begin
            n_region = REGION_AFTER;
            n_u      = (w_cfg.end_time > w_cfg.start_time) ? w_de[QTE_TIME_W-1:0] : '0;
        end else begin
            n_region = REGION_INSIDE;
            n_u      = w_du[QTE_TIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[LAST-1:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u[0]   <= n_u;
            r_reg[0] <= n_region;
            for (int k = 1; k <= U_LAST; k++) begin
                r_u[k] <= r_u[k-1];
            end
            for (int k = 1; k <= LAST; k++) begin
                r_reg[k] <= r_reg[k-1];
            end
        end
    end

    assign w_p_next[0] = w_cfg.c4;
    assign w_p_next[1] = w_cfg.c3;
    assign w_p_next[2] = w_cfg.c2;
    assign w_p_next[3] = w_cfg.c1;
    assign w_p_next[4] = w_cfg.c0;
    assign w_v_next[1] = w_cfg.c4x4;
    assign w_v_next[2] = w_cfg.c3x3;
    assign w_v_next[3] = w_cfg.c2x2;
    assign w_v_next[4] = w_cfg.c1;
    assign w_a_next[2] = w_cfg.c4x12;
    assign w_a_next[3] = w_cfg.c3x6;
    assign w_a_next[4] = w_cfg.c2x2;

    assign w_p_in[0]    = w_cfg.c5;
    assign w_p_ovfin[0] = w_cfg.ovf;

    // position runs all five columns, velocity the last four, acceleration the last three
    for (genvar c = 0; c < N_COL; c++) begin : g_col
        if (c > 0) begin : g_link
            assign w_p_in[c]    = w_p_out[c-1];
            assign w_p_ovfin[c] = w_col_ovf[c-1];
        end

        qte_step #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_p (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_acc  (w_p_in[c]),
            .i_u    (r_u[c*COL_STAGES]),
            .i_next (w_p_next[c]),
            .i_ovf  (w_p_ovfin[c]),
            .o_acc  (w_p_out[c]),
            .o_ovf  (w_p_ovf[c])
        );

        if (c >= 1) begin : g_v
            if (c == 1) begin : g_first
                assign w_v_in[c] = w_cfg.c5x5;
            end else begin : g_chain
                assign w_v_in[c] = w_v_out[c-1];
            end
            qte_step #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_v (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_acc  (w_v_in[c]),
                .i_u    (r_u[c*COL_STAGES]),
                .i_next (w_v_next[c]),
                .i_ovf  (1'b0),
                .o_acc  (w_v_out[c]),
                .o_ovf  (w_v_ovf[c])
            );
        end

        if (c >= 2) begin : g_a
            if (c == 2) begin : g_first
                assign w_a_in[c] = w_cfg.c5x20;
            end else begin : g_chain
                assign w_a_in[c] = w_a_out[c-1];
            end
            qte_step #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_a (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_acc  (w_a_in[c]),
                .i_u    (r_u[c*COL_STAGES]),
                .i_next (w_a_next[c]),
                .i_ovf  (1'b0),
                .o_acc  (w_a_out[c]),
                .o_ovf  (w_a_ovf[c])
            );
        end

        if (c == 0) begin : g_ovf0
            assign w_col_ovf[c] = w_p_ovf[c];
        end else if (c == 1) begin : g_ovf1
            assign w_col_ovf[c] = w_p_ovf[c] | w_v_ovf[c];
        end else begin : g_ovfn
            assign w_col_ovf[c] = w_p_ovf[c] | w_v_ovf[c] | w_a_ovf[c];
        end
    end

    always_comb begin
        w_res.position     = w_p_out[N_COL-1];
        w_res.velocity     = w_v_out[N_COL-1];
        w_res.acceleration = w_a_out[N_COL-1];
        w_res.region       = r_reg[LAST];
        w_res.overflow     = w_col_ovf[N_COL-1];
    end

    qte_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[LAST]),
        .i_data  (w_res),
        .o_en    (w_en),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign s_axis_tready = w_en;
    assign m_axis_tdata  = {w_out.acceleration, w_out.velocity, w_out.position};
    assign m_axis_tuser  = {w_out.overflow, w_out.region};

endmodule

`default_nettype wire
